### design/earliest_free_server_dispatch_macros.svh
// Assertion helpers for the dispatch design; only efsd_ctrl.sv includes them.
`ifndef EARLIEST_FREE_SERVER_DISPATCH_MACROS_SVH
`define EARLIEST_FREE_SERVER_DISPATCH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define EFSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define EFSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/efsd_pkg.sv
package efsd_pkg;

    // Input command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SERVE = 1'b1;

    // Reset value of the active server count
    localparam logic [4:0] ACTIVE_RESET = 5'd16;

    typedef struct packed {
        logic        command;
        logic [3:0]  server_index;
        logic [15:0] service_period;
    } t_in_word;

    typedef struct packed {
        logic [3:0] chosen_server;
        logic       time_overflow;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic load_we;
        logic scan_start;
        logic scan_step;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic single;
        logic at_last;
    } t_dp_status;

endpackage

### design/efsd_dp.sv
module efsd_dp #(
    parameter int NUM_SERVERS = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  efsd_pkg::t_dp_cmd     i_cmd,
    output efsd_pkg::t_dp_status  o_status,
    input  efsd_pkg::t_in_word    i_in_word,
    input  logic                  i_cfg_we,
    input  logic [4:0]            i_cfg_wdata,
    output efsd_pkg::t_out_word   o_out_word
);

    // Only indices below 31 can ever be active, so storage stops there
    localparam int DEPTH = (NUM_SERVERS < 31) ? NUM_SERVERS : 31;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = TIME_BITS + 1;
    localparam logic [4:0] CNT_CAP = (NUM_SERVERS > 31) ? 5'd31 : 5'(NUM_SERVERS);

    logic [15:0]          r_period [DEPTH];
    logic [TIME_BITS-1:0] r_time   [DEPTH];
    logic [4:0]           r_active;
    logic [IDX_W-1:0]     r_scan_idx;
    logic [IDX_W-1:0]     r_best_idx;
    logic [TIME_BITS-1:0] r_best_time;
    efsd_pkg::t_out_word  r_out_word;

    logic [4:0]           w_count;
    logic [IDX_W-1:0]     w_last_idx;
    logic [IDX_W-1:0]     w_load_idx;
    logic                 w_load_ok;
    logic [TIME_BITS-1:0] w_scan_time;
    logic [SUM_W-1:0]     w_sum;
    logic                 w_ovf;
    logic [TIME_BITS-1:0] w_new_time;

    // Clamp the active count to 1 .. min(31, NUM_SERVERS)
    always_comb begin
        w_count = r_active;
        if (w_count == 5'd0) begin
            w_count = 5'd1;
        end
        if (w_count > CNT_CAP) begin
            w_count = CNT_CAP;
        end
    end

    assign w_last_idx = IDX_W'(w_count - 5'd1);
    assign o_status.single  = (w_last_idx == '0);
    assign o_status.at_last = (r_scan_idx == w_last_idx);

    // Loads beyond the server count are dropped
    assign w_load_idx = IDX_W'(i_in_word.server_index);
    assign w_load_ok  = (32'(i_in_word.server_index) < 32'(NUM_SERVERS));

    assign w_scan_time = r_time[r_scan_idx];

    // Add the period with a carry out; saturate on carry
    assign w_sum      = {1'b0, r_best_time} + SUM_W'(r_period[r_best_idx]);
    assign w_ovf      = w_sum[TIME_BITS];
    assign w_new_time = w_ovf ? '1 : w_sum[TIME_BITS-1:0];

    // Hold the active count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= efsd_pkg::ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // Store periods on load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we && w_load_ok) begin
            r_period[w_load_idx] <= i_in_word.service_period;
        end
    end

    // Clear times on reset and load, advance on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_time[i] <= '0;
            end
        end else if (i_cmd.load_we && w_load_ok) begin
            r_time[w_load_idx] <= '0;
        end else if (i_cmd.commit) begin
            r_time[r_best_idx] <= w_new_time;
        end
    end

    // Walk the servers one per cycle, keeping the earliest
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_best_idx  <= '0;
            r_best_time <= r_time[0];
            r_scan_idx  <= IDX_W'(1);
        end else if (i_cmd.scan_step) begin
            if (w_scan_time < r_best_time) begin
                r_best_idx  <= r_scan_idx;
                r_best_time <= w_scan_time;
            end
            r_scan_idx <= r_scan_idx + IDX_W'(1);
        end
    end

    // Load the result word on commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_word.chosen_server <= 4'(r_best_idx);
            r_out_word.time_overflow <= w_ovf;
        end
    end

    assign o_out_word = r_out_word;

endmodule

### design/efsd_ctrl.sv
`include "earliest_free_server_dispatch_macros.svh"

module efsd_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_command,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output efsd_pkg::t_dp_cmd     o_cmd,
    input  efsd_pkg::t_dp_status  i_status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_in_take;
    logic   w_out_take;
    logic   w_slot_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign w_out_take  = r_out_valid && !i_out_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Decode datapath commands and next state
    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (w_out_take) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (w_in_take) begin
                    if (i_command == efsd_pkg::CMD_LOAD) begin
                        o_cmd.load_we = 1'b1;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state = i_status.single ? ST_UPDATE : ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.at_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (w_slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `EFSD_ASSERT_NOW(a_commit_slot_free, i_clk, i_rst_n, o_cmd.commit, w_slot_free, "commit over a waiting word")
    `EFSD_ASSERT_NEXT(a_commit_shows_word, i_clk, i_rst_n, o_cmd.commit, r_out_valid, "committed word not shown")
    `EFSD_ASSERT_NEXT(a_single_to_update, i_clk, i_rst_n, o_cmd.scan_start && i_status.single, r_state == ST_UPDATE, "single server did not skip scan")
    `EFSD_ASSERT_NOW(a_cmd_exclusive, i_clk, i_rst_n, 1'b1, $onehot0(o_cmd), "datapath commands overlap")

endmodule

### design/earliest_free_server_dispatch.sv
// Channel   Direction  Signals                          Word
// input     in         i_in_valid / o_in_stall          i_in_word  (efsd_pkg::t_in_word)
// output    out        o_out_valid / i_out_stall        o_out_word (efsd_pkg::t_out_word)
// config    in         i_cfg_we                         i_cfg_wdata (active server count)
//
// A load word is handled in the idle state. A dispatch word starts a scan: one
// comparator walks the next-free times of the effective active servers one
// server per cycle, then the update state adds the period and writes the time back.
// The commit cycle waits while the previous result word is stalled.
// Reset clears all next-free times at once and sets the active count to 16.
module earliest_free_server_dispatch #(
    parameter int NUM_SERVERS = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  efsd_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output efsd_pkg::t_out_word  o_out_word,
    input  logic                 i_cfg_we,
    input  logic [4:0]           i_cfg_wdata
);

    efsd_pkg::t_dp_cmd    w_cmd;
    efsd_pkg::t_dp_status w_status;

    efsd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_in_word.command),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    efsd_dp #(
        .NUM_SERVERS (NUM_SERVERS),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out_word  (o_out_word)
    );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_SERVERS   = 16;
    localparam int TIME_BITS     = 48;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int ITEMS_PER_SET = 160;
    localparam int NUM_SETS      = 9;
    localparam int CYCLE_LIMIT   = 400000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    efsd_pkg::t_in_word   in_word   = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [4:0]           cfg_wdata = '0;
    logic                 in_stall;
    logic                 out_valid;
    efsd_pkg::t_out_word  out_word;

    // Dispatcher mirror: periods, next-free times and the active count
    logic [15:0]           period_of  [NUM_SERVERS];
    logic [TIME_BITS-1:0]  free_at    [NUM_SERVERS];
    logic [4:0]            active_cnt = efsd_pkg::ACTIVE_RESET;

    efsd_pkg::t_in_word   queued_words[$];
    efsd_pkg::t_out_word  expected_picks[$];
    logic       in_fire       = 1'b0;
    int         fail_count    = 0;
    int         cycle_count   = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         hold_asked    = 0;
    int         hold_taken    = 0;
    int         hold_left     = 0;

    earliest_free_server_dispatch dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned servers_in_play(input logic [4:0] cnt);
        if (cnt == 5'd0)
            return 1;
        if (cnt > NUM_SERVERS)
            return NUM_SERVERS;
        return 32'(cnt);
    endfunction

    // Apply one accepted word to the mirror; queue the pick it causes
    function automatic void track_dispatch(input efsd_pkg::t_in_word w);
        int unsigned          n;
        int unsigned          best;
        logic [TIME_BITS:0]   sum;
        efsd_pkg::t_out_word  pick;
        if (w.command == efsd_pkg::CMD_LOAD) begin
            period_of[w.server_index] = w.service_period;
            free_at[w.server_index]   = '0;
            return;
        end
        n    = servers_in_play(active_cnt);
        best = 0;
        for (int unsigned s = 1; s < n; s++) begin
            if (free_at[s] < free_at[best])
                best = s;
        end
        sum                = {1'b0, free_at[best]} + (TIME_BITS + 1)'(period_of[best]);
        pick.chosen_server = best[3:0];
        pick.time_overflow = sum[TIME_BITS];
        free_at[best]      = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
        expected_picks.push_back(pick);
    endfunction

    // Mostly dispatches; loads lean toward servers in play; periods lean small
    function automatic efsd_pkg::t_in_word random_word(input int unsigned n);
        efsd_pkg::t_in_word w;
        int unsigned        sel;
        w.command      = ($urandom_range(99) < 72) ? efsd_pkg::CMD_SERVE : efsd_pkg::CMD_LOAD;
        w.server_index = ($urandom_range(1) == 0) ? 4'($urandom_range(n - 1))
                                                  : 4'($urandom_range(15));
        sel = $urandom_range(31);
        if (sel == 0)
            w.service_period = 16'd0;
        else if (sel == 1)
            w.service_period = 16'hFFFF;
        else if (sel < 10)
            w.service_period = 16'($urandom_range(1, 4));
        else if (sel < 18)
            w.service_period = 16'($urandom_range(1, 64));
        else
            w.service_period = 16'($urandom_range(65535));
        return w;
    endfunction

    task automatic push_word(input logic cmd, input logic [3:0] idx, input logic [15:0] per);
        efsd_pkg::t_in_word w;
        w.command        = cmd;
        w.server_index   = idx;
        w.service_period = per;
        queued_words.push_back(w);
    endtask

    // Hold until every queued word is taken and every pick has come out
    task automatic wait_drained();
        do @(negedge clk);
        while (queued_words.size() != 0 || expected_picks.size() != 0);
    endtask

    task automatic write_active(input logic [4:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        active_cnt = value;
    endtask

    // Sample handshakes, predict on input words, check output words
    always @(posedge clk) begin : monitor
        efsd_pkg::t_out_word want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d picks outstanding", $time, expected_picks.size());
            $display("CHECK FAILED");
            $finish;
        end
        in_fire <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            track_dispatch(in_word);
        if (rst_n && out_valid && !out_stall) begin
            if (expected_picks.size() == 0) begin
                fail_count++;
                $display("%0t unexpected word: expected none, actual server %0d ovf %0b",
                         $time, out_word.chosen_server, out_word.time_overflow);
            end else begin
                want = expected_picks.pop_front();
                if (out_word.chosen_server !== want.chosen_server) begin
                    fail_count++;
                    $display("%0t chosen_server: expected %0d, actual %0d",
                             $time, want.chosen_server, out_word.chosen_server);
                end
                if (out_word.time_overflow !== want.time_overflow) begin
                    fail_count++;
                    $display("%0t time_overflow: expected %0b, actual %0b",
                             $time, want.time_overflow, out_word.time_overflow);
                end
            end
        end
    end

    // Sender: hold a stalled word, drop the taken one, maybe idle
    always @(negedge clk) begin
        if (in_fire)
            void'(queued_words.pop_front());
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_fire) begin
            in_valid <= 1'b1;
        end else if (queued_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            in_valid <= 1'b1;
            in_word  <= queued_words[0];
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold-off when one is asked for
    always @(negedge clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin
        logic [4:0]  set_value [NUM_SETS];
        int unsigned n;
        set_value = '{5'd1, 5'd0, 5'd31, 5'd2, 5'd5, 5'd17, 5'd16, 5'd3, 5'd12};
        send_idle_pct = 25;
        recv_idle_pct = 54;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        write_active(5'd16);

        // Load every server first so no dispatch ever reads an unloaded period.
        // Server 0 gets the largest period, server 1 the smallest nonzero one, server 2 zero.
        for (int s = 0; s < NUM_SERVERS; s++)
            push_word(efsd_pkg::CMD_LOAD, 4'(s), (s == 0) ? 16'hFFFF : (s == 1) ? 16'd1 :
                                                 (s == 2) ? 16'd0 : 16'(s));
        // All tied at zero: lowest index wins, then the zero-period server sticks
        push_word(efsd_pkg::CMD_SERVE, 4'd0, 16'd0);
        push_word(efsd_pkg::CMD_SERVE, 4'd0, 16'd0);
        push_word(efsd_pkg::CMD_SERVE, 4'd0, 16'd0);
        push_word(efsd_pkg::CMD_SERVE, 4'd0, 16'd0);
        // Reload the sticky server; its time clears and it wins once more
        push_word(efsd_pkg::CMD_LOAD, 4'd2, 16'd7);
        push_word(efsd_pkg::CMD_SERVE, 4'd0, 16'd0);
        push_word(efsd_pkg::CMD_SERVE, 4'd0, 16'd0);
        push_word(efsd_pkg::CMD_SERVE, 4'd15, 16'hFFFF);
        push_word(efsd_pkg::CMD_SERVE, 4'd9, 16'h5A5A);
        wait_drained();

        // Random sets: each writes the count, then pauses the sender midway.
        // Next-free times cannot reach saturation in a run this short.
        for (int p = 0; p < NUM_SETS; p++) begin
            repeat (SETTLE_CYCLES) @(negedge clk);
            write_active(set_value[p]);
            n = servers_in_play(set_value[p]);
            if (p < 3) begin
                send_idle_pct = 25;
                recv_idle_pct = 54;
            end else if (p < 6) begin
                send_idle_pct = 54;
                recv_idle_pct = 25;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p % 3 == 1)
                hold_asked++;
            for (int k = 0; k < ITEMS_PER_SET / 2; k++)
                queued_words.push_back(random_word(n));
            wait_drained();
            for (int k = 0; k < ITEMS_PER_SET / 2; k++)
                queued_words.push_back(random_word(n));
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/efsd_pkg.sv
design/efsd_dp.sv
design/efsd_ctrl.sv
design/earliest_free_server_dispatch.sv
tb/testbench.sv
